### rtl/htok_pkg.sv
package htok_pkg;

  // Input op codes
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_EOS     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Field tags
  localparam logic [1:0] FLD_METHOD = 2'd0;
  localparam logic [1:0] FLD_URL    = 2'd1;
  localparam logic [1:0] FLD_KEY    = 2'd2;
  localparam logic [1:0] FLD_VALUE  = 2'd3;

  // Error causes
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_EOS  = 2'd1;
  localparam logic [1:0] CAUSE_CR   = 2'd2;

  // Parser phases
  localparam logic [3:0] PH_METHOD     = 4'd0;
  localparam logic [3:0] PH_URL        = 4'd1;
  localparam logic [3:0] PH_LINE       = 4'd2;
  localparam logic [3:0] PH_LINE_CR    = 4'd3;
  localparam logic [3:0] PH_KEY        = 4'd4;
  localparam logic [3:0] PH_COLON_SKIP = 4'd5;
  localparam logic [3:0] PH_VALUE      = 4'd6;
  localparam logic [3:0] PH_LF_SKIP    = 4'd7;
  localparam logic [3:0] PH_FINISHED   = 4'd8;

  // Register indexes
  localparam logic [1:0] REG_METHOD_MAX = 2'd0;
  localparam logic [1:0] REG_URL_MAX    = 2'd1;
  localparam logic [1:0] REG_KEY_MAX    = 2'd2;
  localparam logic [1:0] REG_VALUE_MAX  = 2'd3;

  localparam logic [15:0] METHOD_MAX_RST = 16'd64;
  localparam logic [15:0] URL_MAX_RST    = 16'd1024;
  localparam logic [15:0] KEY_MAX_RST    = 16'd1024;
  localparam logic [15:0] VALUE_MAX_RST  = 16'd4096;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [2:0] HOST_FULL     = 3'd4;
  localparam logic [2:0] HOST_MISMATCH = 3'd5;

  function automatic logic [7:0] host_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h48; // H
      2'd1:    c = 8'h6f; // o
      2'd2:    c = 8'h73; // s
      default: c = 8'h74; // t
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] field;
    logic [7:0] data_byte;
    logic       is_host;
    logic [1:0] error_cause;
  } out_item_t;

  typedef struct packed {
    logic [15:0] method_max;
    logic [15:0] url_max;
    logic [15:0] key_max;
    logic [15:0] value_max;
  } limits_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] remaining;
    logic        limit_pending;
    logic [2:0]  host_prog;
    logic        host_flag;
  } parse_state_t;

endpackage

### rtl/htok_cfg.sv
module htok_cfg import htok_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output limits_t     limits_o
);

  limits_t limits_q, limits_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    limits_d = limits_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_METHOD_MAX: limits_d.method_max = cfg_data_i;
        REG_URL_MAX:    limits_d.url_max    = cfg_data_i;
        REG_KEY_MAX:    limits_d.key_max    = cfg_data_i;
        REG_VALUE_MAX:  limits_d.value_max  = cfg_data_i;
        default:        limits_d = limits_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.method_max <= METHOD_MAX_RST;
      limits_q.url_max    <= URL_MAX_RST;
      limits_q.key_max    <= KEY_MAX_RST;
      limits_q.value_max  <= VALUE_MAX_RST;
    end else begin
      limits_q <= limits_d;
    end
  end

  assign limits_o = limits_q;

endmodule

### rtl/htok_step.sv
module htok_step import htok_pkg::*; (
  input  parse_state_t state_i,
  input  in_item_t     item_i,
  input  limits_t      limits_i,
  output parse_state_t state_o,
  output logic         res_valid_o,
  output out_item_t    res_o
);

  logic [15:0] lim_sel;
  logic [15:0] cur_rem;
  logic        keep;
  logic [7:0]  b;

  assign b = item_i.byte_in;

  // Limit for the field of the current phase; sampled on the field's first byte.
  always_comb begin
    case (state_i.phase)
      PH_METHOD: lim_sel = limits_i.method_max;
      PH_URL:    lim_sel = limits_i.url_max;
      PH_KEY:    lim_sel = limits_i.key_max;
      default:   lim_sel = limits_i.value_max;
    endcase
  end

  assign cur_rem = state_i.limit_pending ? lim_sel : state_i.remaining;
  assign keep    = (cur_rem != 16'd0);

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (item_i.op == OP_RESTART) begin
      state_o.phase         = PH_METHOD;
      state_o.limit_pending = 1'b1;
      state_o.remaining     = limits_i.method_max;
      state_o.host_prog     = 3'd0;
      state_o.host_flag     = 1'b0;
    end else if (item_i.op == OP_EOS && state_i.phase != PH_FINISHED) begin
      state_o.phase = PH_FINISHED;
      res_valid_o   = 1'b1;
      if (state_i.phase == PH_KEY || state_i.phase == PH_LF_SKIP) begin
        res_o.kind = KIND_DONE;
      end else begin
        res_o.kind        = KIND_ERROR;
        res_o.error_cause = CAUSE_EOS;
      end
    end else if (item_i.op == OP_DATA && state_i.phase != PH_FINISHED) begin
      case (state_i.phase)
        PH_METHOD, PH_URL: begin
          res_o.field = (state_i.phase == PH_METHOD) ? FLD_METHOD : FLD_URL;
          if (b == CH_SPACE) begin
            state_o.phase         = (state_i.phase == PH_METHOD) ? PH_URL : PH_LINE;
            state_o.limit_pending = 1'b1;
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_END;
          end else if (b == CH_CR) begin
            state_o.phase     = PH_FINISHED;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_ERROR;
            res_o.field       = FLD_METHOD;
            res_o.error_cause = CAUSE_CR;
          end else begin
            state_o.limit_pending = 1'b0;
            state_o.remaining     = keep ? cur_rem - 16'd1 : cur_rem;
            res_valid_o           = keep;
            res_o.kind            = KIND_BYTE;
            res_o.data_byte       = b;
          end
        end
        PH_LINE: begin
          if (b == CH_CR) state_o.phase = PH_LINE_CR;
        end
        PH_LINE_CR: begin
          if (b == CH_LF) begin
            state_o.phase         = PH_KEY;
            state_o.limit_pending = 1'b1;
            state_o.host_prog     = 3'd0;
            state_o.host_flag     = 1'b0;
          end else if (b != CH_CR) begin
            state_o.phase = PH_LINE;
          end
        end
        PH_KEY: begin
          if (b == CH_COLON) begin
            state_o.host_flag     = (state_i.host_prog == HOST_FULL);
            state_o.phase         = PH_COLON_SKIP;
            state_o.limit_pending = 1'b1;
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_END;
            res_o.field           = FLD_KEY;
            res_o.is_host         = (state_i.host_prog == HOST_FULL);
          end else if (b == CH_CR) begin
            state_o.phase = PH_FINISHED;
            res_valid_o   = 1'b1;
            res_o.kind    = KIND_DONE;
          end else begin
            state_o.limit_pending = 1'b0;
            state_o.remaining     = keep ? cur_rem - 16'd1 : cur_rem;
            if (keep) begin
              if (state_i.host_prog < HOST_FULL && b == host_char(state_i.host_prog[1:0])) begin
                state_o.host_prog = state_i.host_prog + 3'd1;
              end else begin
                state_o.host_prog = HOST_MISMATCH;
              end
            end
            res_valid_o     = keep;
            res_o.kind      = KIND_BYTE;
            res_o.field     = FLD_KEY;
            res_o.data_byte = b;
          end
        end
        PH_COLON_SKIP: begin
          state_o.phase         = PH_VALUE;
          state_o.limit_pending = 1'b1;
        end
        PH_VALUE: begin
          res_o.field   = FLD_VALUE;
          res_o.is_host = state_i.host_flag;
          res_valid_o   = 1'b1;
          if (b == CH_CR) begin
            state_o.phase         = PH_LF_SKIP;
            state_o.limit_pending = 1'b1;
            res_o.kind            = KIND_END;
          end else begin
            state_o.limit_pending = 1'b0;
            state_o.remaining     = keep ? cur_rem - 16'd1 : cur_rem;
            res_valid_o           = keep;
            res_o.kind            = KIND_BYTE;
            res_o.data_byte       = b;
          end
        end
        PH_LF_SKIP: begin
          state_o.phase         = PH_KEY;
          state_o.limit_pending = 1'b1;
          state_o.host_prog     = 3'd0;
          state_o.host_flag     = 1'b0;
        end
        default: begin
          state_o.phase = PH_FINISHED;
        end
      endcase
    end
  end

endmodule

### rtl/http_request_head_tokenizer_top.sv
// Path: an accepted item is held in the input register; its result (if any)
//   is written to the result register when the item retires, and is driven from there.
// Throughput: one item per cycle while the result slot is not stalled; the parser state update is combinational.
// Reset (async, active low): limits return to 64/1024/1024/4096, parser to the
//   method phase, both pipeline registers empty.
module http_request_head_tokenizer_top import htok_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  limits_t      limits;

  // input register
  logic         s1_valid_q, s1_valid_d;
  in_item_t     s1_item_q;

  // parser state
  parse_state_t state_q, state_d;

  // result register
  logic         out_valid_q, out_valid_d;
  out_item_t    out_item_q;

  logic         res_valid;
  out_item_t    res;
  logic         out_free;
  logic         s1_adv;

  htok_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .limits_o    (limits)
  );

  htok_step u_step (
    .state_i     (state_q),
    .item_i      (s1_item_q),
    .limits_i    (limits),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output slot frees when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  // The held item retires when it makes no result or the result has a slot.
  assign s1_adv   = s1_valid_q && (!res_valid || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q              <= 1'b0;
      out_valid_q             <= 1'b0;
      state_q.phase           <= PH_METHOD;
      state_q.remaining       <= METHOD_MAX_RST;
      state_q.limit_pending   <= 1'b1;
      state_q.host_prog       <= 3'd0;
      state_q.host_flag       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

### bench/http_request_head_tokenizer_top_test.sv
module http_request_head_tokenizer_top_test import htok_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // An accepted item's result passes through the input and result registers; the
  // extra drain wait covers items that produce nothing but are still in flight.
  localparam int DRAIN_CYCLES = 4;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 500;
  localparam int SCRIPT_LEN = 25;
  localparam int RANDOM_ITEMS = 1525;
  localparam int SETTING_COUNT = 8;

  // op code the block ignores
  localparam logic [1:0] OP_SPARE = 2'd3;
  // field tag carried by done and error items
  localparam logic [1:0] FLD_NONE = 2'd0;
  localparam logic [31:0] HOST_WORD = "Host";
  localparam out_item_t NO_RESULT = '0;

  // How a script row is checked: by the predictor, as giving no result, or against a typed result.
  typedef enum logic [1:0] {
    CHK_PREDICT = 2'b00,
    CHK_SILENT  = 2'b10,
    CHK_TYPED   = 2'b11
  } chk_mode_e;

  typedef struct packed {
    in_item_t  stim;
    chk_mode_e mode;
    out_item_t want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_METHOD_MAX;
  logic [15:0] cfg_data_i = '0;

  http_request_head_tokenizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Tokenizer predictor: own copy of the limits and the parse state
  // ---------------------------------------------------------------------
  logic [15:0] lim_method = METHOD_MAX_RST;
  logic [15:0] lim_url    = URL_MAX_RST;
  logic [15:0] lim_key    = KEY_MAX_RST;
  logic [15:0] lim_value  = VALUE_MAX_RST;

  logic [3:0]  parse_phase = PH_METHOD;
  logic [15:0] room_left   = METHOD_MAX_RST;
  logic        lim_pending = 1'b1;   // limit loads at first byte of a field
  logic [2:0]  host_prog   = '0;     // 0..4 chars of Host matched, or mismatch
  logic        host_flag   = 1'b0;

  out_item_t   result_q[$];          // tokens still owed by the block
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  bit          calm = 1'b0;          // no idling on either side while set

  function automatic void enter_phase(input logic [3:0] p);
    parse_phase = p;
    lim_pending = 1'b1;
  endfunction

  function automatic void start_request();
    enter_phase(PH_METHOD);
    room_left = lim_method;
    host_prog = '0;
    host_flag = 1'b0;
  endfunction

  function automatic void start_header();
    enter_phase(PH_KEY);
    host_prog = '0;
    host_flag = 1'b0;
  endfunction

  // Room check for one byte of the current field; true when the byte is kept.
  function automatic bit keep_byte(input logic [15:0] limit);
    if (lim_pending) begin
      room_left = limit;
      lim_pending = 1'b0;
    end
    if (room_left == 16'd0) return 1'b0;
    room_left = room_left - 16'd1;
    return 1'b1;
  endfunction

  // Advances the parse state by one item; returns 1 when a token comes out.
  function automatic bit tokenize(input in_item_t it, output out_item_t tok);
    logic [7:0] b;
    logic [1:0] fld;
    logic [3:0] was;
    tok = NO_RESULT;
    b = it.byte_in;
    if (it.op == OP_RESTART) begin
      start_request();
      return 1'b0;
    end
    if (it.op == OP_SPARE || parse_phase == PH_FINISHED) return 1'b0;

    if (it.op == OP_EOS) begin
      was = parse_phase;
      parse_phase = PH_FINISHED;
      if (was == PH_KEY || was == PH_LF_SKIP) begin
        tok.kind = KIND_DONE;
      end else begin
        tok.kind = KIND_ERROR;
        tok.error_cause = CAUSE_EOS;
      end
      return 1'b1;
    end

    case (parse_phase)
      PH_METHOD, PH_URL: begin
        fld = (parse_phase == PH_METHOD) ? FLD_METHOD : FLD_URL;
        if (b == CH_SPACE) begin
          enter_phase((parse_phase == PH_METHOD) ? PH_URL : PH_LINE);
          tok.kind = KIND_END;
          tok.field = fld;
          return 1'b1;
        end
        if (b == CH_CR) begin
          parse_phase = PH_FINISHED;
          tok.kind = KIND_ERROR;
          tok.error_cause = CAUSE_CR;
          return 1'b1;
        end
        if (!keep_byte((fld == FLD_METHOD) ? lim_method : lim_url)) return 1'b0;
        tok.kind = KIND_BYTE;
        tok.field = fld;
        tok.data_byte = b;
        return 1'b1;
      end
      PH_LINE: begin
        if (b == CH_CR) parse_phase = PH_LINE_CR;
        return 1'b0;
      end
      PH_LINE_CR: begin
        // a lone CR drops back to the line, CR CR stays here
        if (b == CH_LF) start_header();
        else if (b != CH_CR) parse_phase = PH_LINE;
        return 1'b0;
      end
      PH_KEY: begin
        if (b == CH_COLON) begin
          host_flag = (host_prog == HOST_FULL);
          enter_phase(PH_COLON_SKIP);
          tok.kind = KIND_END;
          tok.field = FLD_KEY;
          tok.is_host = host_flag;
          return 1'b1;
        end
        if (b == CH_CR) begin
          // blank line: request complete, partial key thrown away
          parse_phase = PH_FINISHED;
          tok.kind = KIND_DONE;
          return 1'b1;
        end
        if (!keep_byte(lim_key)) return 1'b0;
        if (host_prog < HOST_FULL && b == HOST_WORD[8 * (3 - host_prog[1:0]) +: 8])
          host_prog = host_prog + 3'd1;
        else
          host_prog = HOST_MISMATCH;
        tok.kind = KIND_BYTE;
        tok.field = FLD_KEY;
        tok.data_byte = b;
        return 1'b1;
      end
      PH_COLON_SKIP: begin
        enter_phase(PH_VALUE);
        return 1'b0;
      end
      PH_VALUE: begin
        if (b == CH_CR) begin
          enter_phase(PH_LF_SKIP);
          tok.kind = KIND_END;
          tok.field = FLD_VALUE;
          tok.is_host = host_flag;
          return 1'b1;
        end
        if (!keep_byte(lim_value)) return 1'b0;
        tok.kind = KIND_BYTE;
        tok.field = FLD_VALUE;
        tok.data_byte = b;
        tok.is_host = host_flag;
        return 1'b1;
      end
      PH_LF_SKIP: begin
        start_header();
        return 1'b0;
      end
      default: begin
        parse_phase = PH_FINISHED;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Directed script: one short request walked end to end at reset limits,
  // then the ignore-after-done, spare op, CR in method and bare EOS cases.
  // ---------------------------------------------------------------------
  function automatic script_row_t script_row(input int idx);
    script_row_t r;
    case (idx)
      0:  r = {OP_DATA, "G", CHK_TYPED, KIND_BYTE, FLD_METHOD, "G", 1'b0, CAUSE_NONE};
      1:  r = {OP_DATA, 8'hff, CHK_TYPED, KIND_BYTE, FLD_METHOD, 8'hff, 1'b0, CAUSE_NONE};
      2:  r = {OP_DATA, 8'h00, CHK_TYPED, KIND_BYTE, FLD_METHOD, 8'h00, 1'b0, CAUSE_NONE};
      3:  r = {OP_DATA, CH_SPACE, CHK_TYPED, KIND_END, FLD_METHOD, 8'h00, 1'b0, CAUSE_NONE};
      4:  r = {OP_DATA, "/", CHK_PREDICT, NO_RESULT};
      5:  r = {OP_DATA, CH_SPACE, CHK_TYPED, KIND_END, FLD_URL, 8'h00, 1'b0, CAUSE_NONE};
      6:  r = {OP_DATA, "H", CHK_SILENT, NO_RESULT};     // rest of request line
      7:  r = {OP_DATA, CH_CR, CHK_SILENT, NO_RESULT};
      8:  r = {OP_DATA, CH_CR, CHK_SILENT, NO_RESULT};   // second CR, still waits LF
      9:  r = {OP_DATA, CH_LF, CHK_SILENT, NO_RESULT};
      10: r = {OP_DATA, "H", CHK_PREDICT, NO_RESULT};
      11: r = {OP_DATA, "o", CHK_PREDICT, NO_RESULT};
      12: r = {OP_DATA, "s", CHK_PREDICT, NO_RESULT};
      13: r = {OP_DATA, "t", CHK_PREDICT, NO_RESULT};
      14: r = {OP_DATA, CH_COLON, CHK_TYPED, KIND_END, FLD_KEY, 8'h00, 1'b1, CAUSE_NONE};
      15: r = {OP_DATA, CH_SPACE, CHK_SILENT, NO_RESULT};
      16: r = {OP_DATA, "x", CHK_PREDICT, NO_RESULT};
      17: r = {OP_DATA, CH_CR, CHK_TYPED, KIND_END, FLD_VALUE, 8'h00, 1'b1, CAUSE_NONE};
      18: r = {OP_EOS, 8'h00, CHK_TYPED, KIND_DONE, FLD_NONE, 8'h00, 1'b0, CAUSE_NONE};
      19: r = {OP_DATA, "a", CHK_SILENT, NO_RESULT};     // ignored after done
      20: r = {OP_SPARE, 8'hff, CHK_SILENT, NO_RESULT};
      21: r = {OP_RESTART, 8'h00, CHK_SILENT, NO_RESULT};
      22: r = {OP_DATA, CH_CR, CHK_TYPED, KIND_ERROR, FLD_NONE, 8'h00, 1'b0, CAUSE_CR};
      23: r = {OP_RESTART, 8'hff, CHK_SILENT, NO_RESULT};
      default: r = {OP_EOS, 8'hff, CHK_TYPED, KIND_ERROR, FLD_NONE, 8'h00, 1'b0, CAUSE_EOS};
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers. Called at a rising edge, return at the accepting edge.
  // Ready is sampled at the falling edge, where nothing is changing.
  // ---------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input chk_mode_e mode,
                           input out_item_t want);
    bit        acc;
    bit        has;
    out_item_t tok;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
    end while (!acc);
    has = tokenize(it, tok);
    if (mode != CHK_PREDICT) begin
      has = (mode == CHK_TYPED);
      tok = want;
    end
    if (has) result_q.push_back(tok);
    items_sent++;
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_limit(input logic [1:0] idx, input logic [15:0] val);
    bit acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    case (idx)
      REG_METHOD_MAX: lim_method = val;
      REG_URL_MAX:    lim_url = val;
      REG_KEY_MAX:    lim_key = val;
      default:        lim_value = val;
    endcase
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Random request builder
  // ---------------------------------------------------------------------
  // Mostly letters, sometimes any byte other than the two barred ones.
  function automatic logic [7:0] pick_byte(input logic [7:0] bar_a, input logic [7:0] bar_b);
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) begin
      c = 8'($urandom_range(8'h41, 8'h7a));
    end else begin
      do c = 8'($urandom); while (c == bar_a || c == bar_b);
    end
    return c;
  endfunction

  // Short fields mostly; now and then one of 60 to 70 bytes, around the 64 default.
  function automatic int field_len();
    if ($urandom_range(0, 49) == 0) return $urandom_range(60, 70);
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'($urandom_range(2, 5));
      3:       return 16'($urandom_range(6, 20));
      4:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_request();
    in_item_t req[$];
    string    key_txt;
    int       n;
    int       cut;
    in_item_t noise;
    if ($urandom_range(0, 9) != 0) req.push_back({OP_RESTART, 8'($urandom)});

    // request line: method, URL, skipped rest with the odd lone CR
    n = field_len();
    repeat (n) req.push_back({OP_DATA, pick_byte(CH_SPACE, CH_CR)});
    req.push_back({OP_DATA, CH_SPACE});
    n = field_len();
    repeat (n) req.push_back({OP_DATA, pick_byte(CH_SPACE, CH_CR)});
    req.push_back({OP_DATA, CH_SPACE});
    n = $urandom_range(0, 6);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) req.push_back({OP_DATA, CH_CR});
      req.push_back({OP_DATA, pick_byte(CH_CR, CH_LF)});
    end
    req.push_back({OP_DATA, CH_CR});
    req.push_back({OP_DATA, CH_LF});

    // header lines, Host and near misses weighted up
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1, 2: key_txt = "Host";
        3:       key_txt = "Hos";
        4:       key_txt = "Hostx";
        5:       key_txt = "host";
        6:       key_txt = "HHost";
        default: key_txt = "";
      endcase
      for (int i = 0; i < key_txt.len(); i++) req.push_back({OP_DATA, key_txt[i]});
      if (key_txt.len() == 0) begin
        repeat (field_len()) req.push_back({OP_DATA, pick_byte(CH_COLON, CH_CR)});
      end
      req.push_back({OP_DATA, CH_COLON});
      req.push_back({OP_DATA, ($urandom_range(0, 3) != 0) ? CH_SPACE : 8'($urandom)});
      repeat (field_len()) req.push_back({OP_DATA, pick_byte(CH_CR, CH_CR)});
      req.push_back({OP_DATA, CH_CR});
      req.push_back({OP_DATA, ($urandom_range(0, 3) != 0) ? CH_LF : 8'($urandom)});
    end

    // close: blank line, EOS at a key, or EOS in place of the last LF
    case ($urandom_range(0, 3))
      0, 1: begin
        req.push_back({OP_DATA, CH_CR});
        req.push_back({OP_DATA, CH_LF});   // lands after done, ignored
      end
      2: req.push_back({OP_EOS, 8'($urandom)});
      default: begin
        void'(req.pop_back());
        req.push_back({OP_EOS, 8'($urandom)});
      end
    endcase

    // broken requests: cut short by EOS, or a CR dropped in anywhere
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(0, req.size() - 1);
      while (req.size() > cut) void'(req.pop_back());
      req.push_back({OP_EOS, 8'($urandom)});
    end else if ($urandom_range(0, 7) == 0) begin
      req[$urandom_range(0, req.size() - 1)] = {OP_DATA, CH_CR};
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) req.push_back({2'($urandom_range(0, 1)), 8'($urandom)});
    end

    foreach (req[i]) begin
      if ($urandom_range(0, 49) == 0) begin
        noise = {2'($urandom_range(0, 3)), 8'($urandom)};
        send_item(noise, CHK_PREDICT, NO_RESULT);
      end
      send_item(req[i], CHK_PREDICT, NO_RESULT);
    end
  endtask

  // Limit settings between request batches: all zero, all max, then mixes.
  task automatic set_limits(input int setting);
    logic [15:0] v_method;
    logic [15:0] v_url;
    logic [15:0] v_key;
    logic [15:0] v_value;
    case (setting)
      1: begin
        v_method = '0; v_url = '0; v_key = '0; v_value = '0;
      end
      2: begin
        v_method = '1; v_url = '1; v_key = '1; v_value = '1;
      end
      default: begin
        v_method = pick_limit();
        v_url = pick_limit();
        v_key = pick_limit();
        v_value = pick_limit();
      end
    endcase
    write_limit(REG_METHOD_MAX, v_method);
    write_limit(REG_URL_MAX, v_url);
    write_limit(REG_KEY_MAX, v_key);
    write_limit(REG_VALUE_MAX, v_value);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall bursts unless calm
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Token checker: every accepted token against the oldest one owed.
  out_item_t want_tok;

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: token with none owed: kind=%0d field=%0d byte=%02h host=%0d cause=%0d",
                   $time, out_data_o.kind, out_data_o.field, out_data_o.data_byte,
                   out_data_o.is_host, out_data_o.error_cause);
      end else begin
        want_tok = result_q.pop_front();
        if (out_data_o.kind !== want_tok.kind || out_data_o.field !== want_tok.field ||
            out_data_o.data_byte !== want_tok.data_byte ||
            out_data_o.is_host !== want_tok.is_host ||
            out_data_o.error_cause !== want_tok.error_cause) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: token mismatch: exp kind=%0d field=%0d byte=%02h host=%0d cause=%0d",
                     $time, want_tok.kind, want_tok.field, want_tok.data_byte,
                     want_tok.is_host, want_tok.error_cause);
            $display("  got kind=%0d field=%0d byte=%02h host=%0d cause=%0d",
                     out_data_o.kind, out_data_o.field, out_data_o.data_byte,
                     out_data_o.is_host, out_data_o.error_cause);
          end
        end
      end
    end
  end

  // Hang detector: cycles with no handshake on any channel.
  int unsigned quiet_cycles = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no handshake for %0d cycles, %0d tokens owed",
                   $time, quiet_cycles, result_q.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    script_row_t row;
    start_request();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row = script_row(i);
      send_item(row.stim, row.mode, row.want);
    end

    // Setting 0 keeps the reset limits; one middle batch and the last run
    // without any idling.
    for (int s = 0; s < SETTING_COUNT; s++) begin
      if (s > 0) begin
        in_valid_i <= 1'b0;
        wait_drained();
        set_limits(s);
      end
      calm = (s == 4) || (s == SETTING_COUNT - 1);
      while (items_sent < SCRIPT_LEN + (s + 1) * RANDOM_ITEMS / SETTING_COUNT)
        send_request();
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/htok_pkg.sv
rtl/htok_cfg.sv
rtl/htok_step.sv
rtl/http_request_head_tokenizer_top.sv
bench/http_request_head_tokenizer_top_test.sv
